FILE: hw/rtl/key_hold_detector_macros.svh
// assertion macros for the key hold detector
`ifndef KEY_HOLD_DETECTOR_MACROS_SVH
`define KEY_HOLD_DETECTOR_MACROS_SVH

// same-cycle implication, sampled on the rising clock edge
`define KHD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on the rising clock edge
`define KHD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

FILE: hw/rtl/khd_pkg.sv
// shared types and constants of the key hold detector
package khd_pkg;

    localparam logic [1:0] KIND_EVENT = 2'd0;
    localparam logic [1:0] KIND_TICK  = 2'd1;
    localparam logic [1:0] KIND_CLEAR = 2'd2;

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_DURATION = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_REPORT_ENABLE = 1'b1;

    localparam int HOLD_DURATION_RESET = 500;
    localparam int MAX_REPORTS = 16;
    localparam int CNT_W = $clog2(MAX_REPORTS + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_SCAN,
        ST_APPLY,
        ST_FLUSH
    } t_state;

    typedef struct packed {
        logic load;
        logic scan;
        logic apply;
        logic flush;
        logic clear;
    } t_cmd;

    typedef struct packed {
        logic [1:0] kind;
        logic       scan_done;
    } t_sts;

    typedef struct packed {
        logic [15:0] key_id;
        logic [31:0] press_start;
    } t_slot;

endpackage

FILE: hw/rtl/khd_ctrl.sv
// controller state machine: sequences load, dispatch, slot scan, update, flush and clear
module khd_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  khd_pkg::t_sts i_sts,
    output khd_pkg::t_cmd o_cmd,
    output logic          o_busy
);
    import khd_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                case (i_sts.kind)
                    KIND_EVENT: n_state = ST_SCAN;
                    KIND_TICK:  n_state = ST_SCAN;
                    KIND_CLEAR: begin
                        o_cmd.clear = 1'b1;
                        n_state     = ST_IDLE;
                    end
                    default:    n_state = ST_IDLE;
                endcase
            end
            ST_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.scan_done) begin
                    n_state = (i_sts.kind == KIND_EVENT) ? ST_APPLY : ST_FLUSH;
                end
            end
            ST_APPLY: begin
                o_cmd.apply = 1'b1;
                n_state     = ST_IDLE;
            end
            ST_FLUSH: begin
                o_cmd.flush = 1'b1;
                n_state     = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_busy = (r_state != ST_IDLE);

endmodule

FILE: hw/rtl/khd_dp.sv
// datapath: slot table, config registers, due check and report output
module khd_dp #(
    parameter int KEY_SLOTS = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  khd_pkg::t_cmd                    i_cmd,
    output khd_pkg::t_sts                    o_sts,
    input  logic [1:0]                       i_kind,
    input  logic [7:0]                       i_key_usage,
    input  logic [7:0]                       i_key_modifiers,
    input  logic                             i_is_press,
    input  logic [31:0]                      i_event_time,
    input  logic [31:0]                      i_current_time,
    input  logic                             i_cfg_valid,
    input  logic [khd_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [31:0]                      i_cfg_data,
    output logic                             o_hold_valid,
    output logic [7:0]                       o_hold_usage,
    output logic [7:0]                       o_hold_modifiers,
    output logic                             o_last_report
);
    import khd_pkg::*;

    localparam int SLOT_W = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(KEY_SLOTS - 1);

    // slot table
    t_slot                r_mem [KEY_SLOTS];
    t_slot                r_q;
    logic [KEY_SLOTS-1:0] r_valid;
    logic [KEY_SLOTS-1:0] r_pressed;
    logic [KEY_SLOTS-1:0] r_reported;

    // latched request
    logic [1:0]  r_kind;
    logic [15:0] r_id;
    logic        r_press;
    logic [31:0] r_ev_time;
    logic [31:0] r_now;

    // scan pipeline
    logic [SLOT_W-1:0] r_rd_addr;
    logic              r_issue_on;
    logic              r_ev_valid;
    logic [SLOT_W-1:0] r_ev_addr;

    logic              r_match_found;
    logic [SLOT_W-1:0] r_match_slot;
    logic              r_free_found;
    logic [SLOT_W-1:0] r_free_slot;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_pend_valid;
    logic [15:0]       r_pend_id;

    logic [31:0] r_hold_duration;
    logic        r_report_enable;

    logic        r_out_valid;
    logic [15:0] r_out_id;
    logic        r_out_last;

    logic [31:0]       w_tick_age;
    logic              w_tick_due;
    logic              w_key_match;
    logic              w_key_free;
    logic [31:0]       w_start;
    logic [31:0]       w_press_age;
    logic              w_press_due;
    logic [SLOT_W-1:0] w_slot;
    logic              w_apply;

    always_comb begin
        w_tick_age  = r_now - r_q.press_start;
        w_tick_due  = r_ev_valid && (r_kind == KIND_TICK) && r_report_enable
                      && r_pressed[r_ev_addr] && !r_reported[r_ev_addr]
                      && (w_tick_age >= r_hold_duration)
                      && (r_cnt < CNT_W'(MAX_REPORTS));
        w_key_match = r_ev_valid && r_valid[r_ev_addr] && (r_q.key_id == r_id);
        w_key_free  = r_ev_valid && !r_valid[r_ev_addr] && !r_free_found;
        w_start     = (r_ev_time != 32'd0) ? r_ev_time : r_now;
        w_press_age = r_now - w_start;
        w_press_due = r_press && r_report_enable && (w_press_age >= r_hold_duration);
        w_slot      = r_match_found ? r_match_slot : r_free_slot;
        w_apply     = i_cmd.apply && (r_match_found || r_free_found);
    end

    // table memory
    always_ff @(posedge i_clk) begin
        if (w_apply) begin
            r_mem[w_slot] <= '{key_id: r_id, press_start: (r_press ? w_start : 32'd0)};
        end
        r_q <= r_mem[r_rd_addr];
    end

    // request payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind    <= i_kind;
            r_id      <= {i_key_modifiers, i_key_usage};
            r_press   <= i_is_press;
            r_ev_time <= i_event_time;
            r_now     <= i_current_time;
        end
    end

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_duration <= 32'(HOLD_DURATION_RESET);
            r_report_enable <= 1'b1;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_HOLD_DURATION: r_hold_duration <= i_cfg_data;
                CFG_REPORT_ENABLE: r_report_enable <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // slot flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            r_valid    <= '0;
            r_pressed  <= '0;
            r_reported <= '0;
        end else if (w_apply) begin
            r_valid[w_slot]    <= 1'b1;
            r_pressed[w_slot]  <= r_press;
            r_reported[w_slot] <= w_press_due;
        end else if (w_tick_due) begin
            r_reported[r_ev_addr] <= 1'b1;
        end
    end

    // scan control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_issue_on    <= 1'b0;
            r_ev_valid    <= 1'b0;
            r_match_found <= 1'b0;
            r_free_found  <= 1'b0;
            r_cnt         <= '0;
            r_pend_valid  <= 1'b0;
        end else if (i_cmd.load) begin
            r_rd_addr     <= '0;
            r_issue_on    <= 1'b1;
            r_ev_valid    <= 1'b0;
            r_match_found <= 1'b0;
            r_free_found  <= 1'b0;
            r_cnt         <= '0;
            r_pend_valid  <= 1'b0;
        end else begin
            r_ev_valid <= i_cmd.scan && r_issue_on;
            r_ev_addr  <= r_rd_addr;
            if (i_cmd.scan && r_issue_on) begin
                if (r_rd_addr == LAST_SLOT) begin
                    r_issue_on <= 1'b0;
                end else begin
                    r_rd_addr <= r_rd_addr + 1'b1;
                end
            end
            if (w_key_match) begin
                r_match_found <= 1'b1;
                r_match_slot  <= r_ev_addr;
            end
            if (w_key_free) begin
                r_free_found <= 1'b1;
                r_free_slot  <= r_ev_addr;
            end
            if (w_tick_due) begin
                r_cnt        <= r_cnt + 1'b1;
                r_pend_valid <= 1'b1;
                r_pend_id    <= r_q.key_id;
            end else if (i_cmd.flush) begin
                r_pend_valid <= 1'b0;
            end
        end
    end

    // report output, one cycle strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_apply && w_press_due) begin
            r_out_valid <= 1'b1;
            r_out_id    <= r_id;
            r_out_last  <= 1'b1;
        end else if (w_tick_due && r_pend_valid) begin
            r_out_valid <= 1'b1;
            r_out_id    <= r_pend_id;
            r_out_last  <= 1'b0;
        end else if (i_cmd.flush && r_pend_valid) begin
            r_out_valid <= 1'b1;
            r_out_id    <= r_pend_id;
            r_out_last  <= 1'b1;
        end else begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_sts.kind      = r_kind;
    assign o_sts.scan_done = r_ev_valid && (r_ev_addr == LAST_SLOT);

    assign o_hold_valid     = r_out_valid;
    assign o_hold_usage     = r_out_id[7:0];
    assign o_hold_modifiers = r_out_id[15:8];
    assign o_last_report    = r_out_last;

endmodule

FILE: hw/rtl/key_hold_detector.sv
// key hold detector top level: slot table scan for key events and time ticks
// a key event or tick goes through load, dispatch, one table read per slot and
// the read latency, then an update or flush; a clear ends after dispatch
// the slot memory, with separate read and write ports, is read one slot per cycle
// one report per strobe in tick scan, flush or event update; receiver cannot stall
// synchronous active-low reset empties the table and loads hold_duration 500
module key_hold_detector #(
    parameter int KEY_SLOTS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    output logic                          o_busy,
    input  logic [1:0]                    i_kind,
    input  logic [7:0]                    i_key_usage,
    input  logic [7:0]                    i_key_modifiers,
    input  logic                          i_is_press,
    input  logic [31:0]                   i_event_time,
    input  logic [31:0]                   i_current_time,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [khd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]                   i_cfg_data,
    output logic                          o_hold_valid,
    output logic [7:0]                    o_hold_usage,
    output logic [7:0]                    o_hold_modifiers,
    output logic                          o_last_report
);
    import khd_pkg::*;

    `include "key_hold_detector_macros.svh"

    t_cmd w_cmd;
    t_sts w_sts;
    logic w_start;

    assign w_start     = i_start && !o_busy;
    assign o_cfg_ready = 1'b1;

    khd_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd),
        .o_busy  (o_busy)
    );

    khd_dp #(
        .KEY_SLOTS (KEY_SLOTS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_sts            (w_sts),
        .i_kind           (i_kind),
        .i_key_usage      (i_key_usage),
        .i_key_modifiers  (i_key_modifiers),
        .i_is_press       (i_is_press),
        .i_event_time     (i_event_time),
        .i_current_time   (i_current_time),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .o_hold_valid     (o_hold_valid),
        .o_hold_usage     (o_hold_usage),
        .o_hold_modifiers (o_hold_modifiers),
        .o_last_report    (o_last_report)
    );

    // accepted request keeps the block busy in the next cycle
    `KHD_ASSERT_NEXT(a_busy_after_start, w_start, o_busy, "busy not raised after request")
    // only a scan in progress can emit a report that is not the last
    `KHD_ASSERT_NOW(a_mid_report_busy, o_hold_valid && !o_last_report, o_busy, "non-last report while idle")
    // busy rises only on an accepted request
    `KHD_ASSERT_NOW(a_busy_rise, $rose(o_busy), $past(w_start), "busy raised without request")
    // a load never coincides with scan, update or flush commands
    `KHD_ASSERT_NOW(a_cmd_excl, w_cmd.load, !w_cmd.scan && !w_cmd.apply && !w_cmd.flush, "load overlaps other command")

endmodule
